[hdl/y2b_pkg.sv]
// Shared types, coefficients and arithmetic helpers for the YUYV to BGR converter.
// Used by every module under hdl/; depends on nothing.
`default_nettype none
package y2b_pkg;

    localparam int unsigned PROD_W = 21;
    localparam int unsigned TERM_W = 11;
    localparam int unsigned SUM_W  = 12;

    localparam logic signed [PROD_W-1:0] COEF_LUMA = 21'sd1192;
    localparam logic signed [PROD_W-1:0] COEF_UB   = 21'sd2066;
    localparam logic signed [PROD_W-1:0] COEF_VR   = 21'sd1634;
    localparam logic signed [PROD_W-1:0] COEF_UG   = 21'sd400;
    localparam logic signed [PROD_W-1:0] COEF_VG   = 21'sd832;
    localparam int unsigned SCALE_SHIFT = 10;   // divide by 1024
    localparam logic signed [8:0] LUMA_OFFSET   = 9'sd16;
    localparam logic signed [8:0] CHROMA_OFFSET = 9'sd128;
    localparam logic signed [SUM_W-1:0] CHAN_MAX = 12'sd255;

    // packed with the last field in the low bits
    typedef struct packed {
        logic [7:0] chroma_red;
        logic [7:0] luma_second;
        logic [7:0] chroma_blue;
        logic [7:0] luma_first;
    } t_yuyv;

    typedef struct packed {
        logic [7:0] red_right;
        logic [7:0] green_right;
        logic [7:0] blue_right;
        logic [7:0] red_left;
        logic [7:0] green_left;
        logic [7:0] blue_left;
    } t_bgr;

    typedef struct packed {
        logic signed [PROD_W-1:0] p_y0;
        logic signed [PROD_W-1:0] p_y1;
        logic signed [PROD_W-1:0] p_ub;
        logic signed [PROD_W-1:0] p_vr;
        logic signed [PROD_W-1:0] p_ug;
        logic signed [PROD_W-1:0] p_vg;
    } t_prod;

    typedef struct packed {
        logic signed [TERM_W-1:0] c0;
        logic signed [TERM_W-1:0] c1;
        logic signed [TERM_W-1:0] db;
        logic signed [TERM_W-1:0] dr;
        logic signed [TERM_W-1:0] dg;
    } t_term;

    // product / 1024, rounded toward zero
    function automatic logic signed [TERM_W-1:0] trunc_scale(input logic signed [PROD_W-1:0] p);
        logic signed [TERM_W-1:0] q;
        q = TERM_W'(p >>> SCALE_SHIFT);
        if (p[PROD_W-1] && (p[SCALE_SHIFT-1:0] != '0)) begin
            q = q + TERM_W'(1);
        end
        return q;
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [SUM_W-1:0] v);
        logic [7:0] r;
        if (v[SUM_W-1]) begin
            r = 8'd0;
        end else if (v > CHAN_MAX) begin
            r = 8'd255;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/yuyv_to_bgr_converter.sv]
// YUYV 4:2:2 to BGR converter, BT.601 limited range, top level.
// Instantiates y2b_mult, y2b_scale and y2b_mix; depends on y2b_pkg.
//
// Usage:
//   Slave stream (i_s_*) takes one YUYV macropixel per word: Y0, U, Y1, V
//   from the low byte up. Master stream (o_m_*) gives one word per macropixel
//   holding two BGR pixels, left pixel in the low 24 bits.
//   From input acceptance to o_m_tvalid a word passes products, scaling
//   toward zero, then sum and clamp, one register stage each.
//   Throughput is one word per cycle while i_m_tready stays high; each stage holds its own valid bit.
//   When the receiver stalls, words hold in place and empty stages still
//   fill, so up to three words are buffered before o_s_tready drops.
//   Ready paths run combinationally from i_m_tready back to o_s_tready.
//   Synchronous active-low reset clears all valid bits; the pipeline comes
//   out of reset empty and ready.
`default_nettype none
module yuyv_to_bgr_converter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,  // luma_first, chroma_blue, luma_second, chroma_red
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata   // blue_left, green_left, red_left,
                                         // blue_right, green_right, red_right
);

    logic            s1_valid, s2_valid, s2_ready, s3_ready;
    y2b_pkg::t_prod  s1_data;
    y2b_pkg::t_term  s2_data;
    y2b_pkg::t_bgr   s3_data;
    logic            s_acc;

    y2b_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (y2b_pkg::t_yuyv'(i_s_tdata)),
        .o_valid (s1_valid),
        .i_ready (s2_ready),
        .o_data  (s1_data)
    );

    y2b_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s2_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s3_ready),
        .o_data  (s2_data)
    );

    y2b_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s3_ready),
        .i_data  (s2_data),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (s3_data)
    );

    assign o_m_tdata = s3_data;
    assign s_acc     = i_s_tvalid && o_s_tready;

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tready |-> o_s_tready)
        else $error("input stalled while output drains");

    a_full_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready && s1_valid && s2_valid))
        else $error("input stalled with a bubble in the pipeline");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc ##1 i_m_tready ##1 i_m_tready |=> o_m_tvalid)
        else $error("word did not reach the output in three cycles");

endmodule
`default_nettype wire

[hdl/y2b_mult.sv]
// Stage 1: removes sample offsets and forms the six constant-coefficient products.
// Depends on y2b_pkg.
`default_nettype none
module y2b_mult (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire y2b_pkg::t_yuyv i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output y2b_pkg::t_prod      o_data
);

    logic                         r_valid;
    y2b_pkg::t_prod               r_data;
    y2b_pkg::t_prod               n_data;
    logic signed [y2b_pkg::PROD_W-1:0] y0_ext, y1_ext, u_ext, v_ext;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        y0_ext = y2b_pkg::PROD_W'($signed({1'b0, i_data.luma_first}) - y2b_pkg::LUMA_OFFSET);
        y1_ext = y2b_pkg::PROD_W'($signed({1'b0, i_data.luma_second}) - y2b_pkg::LUMA_OFFSET);
        u_ext  = y2b_pkg::PROD_W'($signed({1'b0, i_data.chroma_blue}) - y2b_pkg::CHROMA_OFFSET);
        v_ext  = y2b_pkg::PROD_W'($signed({1'b0, i_data.chroma_red}) - y2b_pkg::CHROMA_OFFSET);
        n_data.p_y0 = y0_ext * y2b_pkg::COEF_LUMA;
        n_data.p_y1 = y1_ext * y2b_pkg::COEF_LUMA;
        n_data.p_ub = u_ext * y2b_pkg::COEF_UB;
        n_data.p_vr = v_ext * y2b_pkg::COEF_VR;
        n_data.p_ug = u_ext * y2b_pkg::COEF_UG;
        n_data.p_vg = v_ext * y2b_pkg::COEF_VG;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

[hdl/y2b_scale.sv]
// Stage 2: scales each product down by 1024 toward zero and sums the green terms.
// Depends on y2b_pkg.
`default_nettype none
module y2b_scale (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire y2b_pkg::t_prod i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output y2b_pkg::t_term      o_data
);

    logic             r_valid;
    y2b_pkg::t_term   r_data;
    y2b_pkg::t_term   n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data.c0 = y2b_pkg::trunc_scale(i_data.p_y0);
        n_data.c1 = y2b_pkg::trunc_scale(i_data.p_y1);
        n_data.db = y2b_pkg::trunc_scale(i_data.p_ub);
        n_data.dr = y2b_pkg::trunc_scale(i_data.p_vr);
        n_data.dg = y2b_pkg::trunc_scale(i_data.p_ug) + y2b_pkg::trunc_scale(i_data.p_vg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

[hdl/y2b_mix.sv]
// Stage 3: luma plus blue/red terms, luma minus green term, clamped to 0..255.
// Its register is the block's output register. Depends on y2b_pkg.
`default_nettype none
module y2b_mix (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire y2b_pkg::t_term i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output y2b_pkg::t_bgr       o_data
);

    logic            r_valid;
    y2b_pkg::t_bgr   r_data;
    y2b_pkg::t_bgr   n_data;
    logic signed [y2b_pkg::SUM_W-1:0] c0, c1, db, dr, dg;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        c0 = y2b_pkg::SUM_W'(i_data.c0);
        c1 = y2b_pkg::SUM_W'(i_data.c1);
        db = y2b_pkg::SUM_W'(i_data.db);
        dr = y2b_pkg::SUM_W'(i_data.dr);
        dg = y2b_pkg::SUM_W'(i_data.dg);
        n_data.blue_left   = y2b_pkg::clamp8(c0 + db);
        n_data.green_left  = y2b_pkg::clamp8(c0 - dg);
        n_data.red_left    = y2b_pkg::clamp8(c0 + dr);
        n_data.blue_right  = y2b_pkg::clamp8(c1 + db);
        n_data.green_right = y2b_pkg::clamp8(c1 - dg);
        n_data.red_right   = y2b_pkg::clamp8(c1 + dr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

[tb/tb_yuyv_to_bgr_converter.sv]
// Self-checking testbench for yuyv_to_bgr_converter: drives YUYV macropixels on the slave
// stream and checks each BGR word on the master stream against an in-bench predictor.
// Depends on y2b_pkg (t_yuyv, t_bgr) and the converter RTL under hdl/.
module tb_yuyv_to_bgr_converter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 6;
    localparam int GAP_MAX      = 18;
    localparam int DRAIN_CYCLES = 10;
    localparam int STALL_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 80;

    // BT.601 limited-range coefficients, Q10
    localparam int Y_GAIN       = 1192;
    localparam int U_BLUE_GAIN  = 2066;
    localparam int V_RED_GAIN   = 1634;
    localparam int U_GREEN_GAIN = 400;
    localparam int V_GREEN_GAIN = 832;
    localparam int FRAC_DIV     = 1024;
    localparam int Y_BLACK      = 16;
    localparam int UV_ZERO      = 128;
    localparam int CHAN_TOP     = 255;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;   // luma_first, chroma_blue, luma_second, chroma_red
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;         // blue_left, green_left, red_left,
                                    // blue_right, green_right, red_right

    y2b_pkg::t_bgr bgr_expected[$];
    int   error_count = 0;
    bit   tx_idle     = 1'b1;
    bit   rx_idle     = 1'b1;
    int   rx_hold_req = 0;
    int   rx_hold     = 0;
    int   rx_wait     = 0;
    int   idle_cycles = 0;

    yuyv_to_bgr_converter u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic logic [7:0] sat8(input int v);
        if (v < 0) begin
            return 8'd0;
        end
        if (v > CHAN_TOP) begin
            return 8'(CHAN_TOP);
        end
        return 8'(v);
    endfunction

    // {red, green, blue} of one pixel
    function automatic logic [23:0] bgr_pixel(input logic [7:0] y, input int db, input int dg,
                                              input int dr);
        int c;
        c = (int'(y) - Y_BLACK) * Y_GAIN / FRAC_DIV;
        return {sat8(c + dr), sat8(c - dg), sat8(c + db)};
    endfunction

    function automatic y2b_pkg::t_bgr predict_bgr(input y2b_pkg::t_yuyv px);
        int u;
        int v;
        int db;
        int dg;
        int dr;
        u  = int'(px.chroma_blue) - UV_ZERO;
        v  = int'(px.chroma_red) - UV_ZERO;
        db = u * U_BLUE_GAIN / FRAC_DIV;
        dr = v * V_RED_GAIN / FRAC_DIV;
        // two separately truncated products
        dg = u * U_GREEN_GAIN / FRAC_DIV + v * V_GREEN_GAIN / FRAC_DIV;
        return y2b_pkg::t_bgr'({bgr_pixel(px.luma_second, db, dg, dr),
                                bgr_pixel(px.luma_first, db, dg, dr)});
    endfunction

    function automatic y2b_pkg::t_yuyv yuyv(input logic [7:0] y0, input logic [7:0] u,
                                            input logic [7:0] y1, input logic [7:0] v);
        return y2b_pkg::t_yuyv'({v, y1, u, y0});
    endfunction

    function automatic logic [7:0] rand_sample();
        case ($urandom_range(0, 9))
            0: begin
                return 8'd0;
            end
            1: begin
                return 8'd255;
            end
            2: begin
                return 8'($urandom_range(0, 20));
            end
            3: begin
                return 8'($urandom_range(120, 136));
            end
            default: begin
                return 8'($urandom);
            end
        endcase
    endfunction

    function automatic y2b_pkg::t_yuyv rand_yuyv();
        return yuyv(rand_sample(), rand_sample(), rand_sample(), rand_sample());
    endfunction

    task automatic compare_channel(input string name, input logic [7:0] want,
                                   input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_bgr(input y2b_pkg::t_bgr got);
        y2b_pkg::t_bgr want;
        if (bgr_expected.size() == 0) begin
            $error("output word %h with no pending macropixel", got);
            error_count++;
            return;
        end
        want = bgr_expected.pop_front();
        compare_channel("blue_left", want.blue_left, got.blue_left);
        compare_channel("green_left", want.green_left, got.green_left);
        compare_channel("red_left", want.red_left, got.red_left);
        compare_channel("blue_right", want.blue_right, got.blue_right);
        compare_channel("green_right", want.green_right, got.green_right);
        compare_channel("red_right", want.red_right, got.red_right);
    endtask

    // receiver: checks accepted words, draws a random stall per word while rx_idle, honors hold-off requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                check_bgr(y2b_pkg::t_bgr'(o_m_tdata));
            end
            if (rx_hold_req > 0) begin
                rx_hold     = rx_hold_req;
                rx_hold_req = 0;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                rx_wait = 0;
                i_m_tready <= 1'b0;
            end else begin
                if (o_m_tvalid && i_m_tready) begin
                    rx_wait = rx_idle ? int'($urandom_range(0, GAP_MAX)) : 0;
                end else if (rx_wait > 0) begin
                    rx_wait--;
                end
                i_m_tready <= (rx_wait == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("tb_yuyv_to_bgr_converter failed");
        $finish;
    end

    // valid stays high into the next call; a gap lowers it first
    task automatic send_yuyv(input y2b_pkg::t_yuyv px);
        int gap;
        gap = tx_idle ? int'($urandom_range(0, GAP_MAX)) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= px;
        do @(posedge i_clk); while (!o_s_tready);
        bgr_expected.push_back(predict_bgr(px));
    endtask

    task automatic test_corners();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_yuyv(yuyv(8'd0, 8'd0, 8'd0, 8'd0));
        send_yuyv(yuyv(8'd255, 8'd255, 8'd255, 8'd255));
        send_yuyv(yuyv(8'd16, 8'd128, 8'd235, 8'd128));     // black and white, no chroma
        send_yuyv(yuyv(8'd0, 8'd128, 8'd15, 8'd128));       // luma under black level
        send_yuyv(yuyv(8'd17, 8'd128, 8'd14, 8'd128));
        send_yuyv(yuyv(8'd255, 8'd128, 8'd254, 8'd128));    // saturating luma
        send_yuyv(yuyv(8'd128, 8'd0, 8'd128, 8'd0));
        send_yuyv(yuyv(8'd128, 8'd255, 8'd128, 8'd255));
        send_yuyv(yuyv(8'd128, 8'd0, 8'd128, 8'd255));
        send_yuyv(yuyv(8'd128, 8'd255, 8'd128, 8'd0));
        send_yuyv(yuyv(8'd0, 8'd255, 8'd255, 8'd0));
        send_yuyv(yuyv(8'd255, 8'd0, 8'd0, 8'd255));
        send_yuyv(yuyv(8'd100, 8'd127, 8'd101, 8'd127));    // small negative chroma, truncation
        send_yuyv(yuyv(8'd100, 8'd129, 8'd101, 8'd129));
        send_yuyv(yuyv(8'd100, 8'd127, 8'd101, 8'd129));
        send_yuyv(yuyv(8'd60, 8'd129, 8'd61, 8'd127));
        send_yuyv(yuyv(8'd10, 8'd255, 8'd10, 8'd0));        // low luma lifted by chroma
        send_yuyv(yuyv(8'd240, 8'd0, 8'd240, 8'd255));
        send_yuyv(yuyv(8'hAA, 8'h55, 8'h55, 8'hAA));
        send_yuyv(yuyv(8'h55, 8'hAA, 8'hAA, 8'h55));
    endtask

    task automatic test_random_mix(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                tx_idle = 1'($urandom_range(0, 1));
                rx_idle = 1'($urandom_range(0, 1));
            end
            send_yuyv(rand_yuyv());
        end
    endtask

    task automatic test_back_to_back(input int count);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (int n = 0; n < count; n++) begin
            send_yuyv(rand_yuyv());
        end
    endtask

    // receiver holds off while the sender keeps offering; the pipeline fills and stalls
    task automatic test_output_stall(input int rounds, input int count);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (int r = 0; r < rounds; r++) begin
            rx_hold_req = HOLD_CYCLES;
            for (int n = 0; n < count; n++) begin
                send_yuyv(rand_yuyv());
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_corners();
        test_random_mix(900);
        test_back_to_back(250);
        test_output_stall(2, 40);
        i_s_tvalid <= 1'b0;
        while (bgr_expected.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && bgr_expected.size() == 0) begin
            $display("tb_yuyv_to_bgr_converter passed");
        end else begin
            $display("tb_yuyv_to_bgr_converter failed");
        end
        $finish;
    end

endmodule

[files.f]
hdl/y2b_pkg.sv
hdl/y2b_mult.sv
hdl/y2b_scale.sv
hdl/y2b_mix.sv
hdl/yuyv_to_bgr_converter.sv
tb/tb_yuyv_to_bgr_converter.sv
